// ===== rtl/triangle_count_code_pruned_macros.svh =====
// Assertion macros used by the triangle counter checker.
`ifndef TRIANGLE_COUNT_CODE_PRUNED_MACROS_SVH
`define TRIANGLE_COUNT_CODE_PRUNED_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcc check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcc check failed");

`endif

// ===== rtl/tcc_pkg.sv =====
// Shared types and constants of the triangle counter.
package tcc_pkg;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 8192;
    localparam int DEF_CODE_BITS = 64;

    localparam int VID_W        = 10;
    localparam int CODE_W       = 64;
    localparam int COUNT_W      = 40;
    localparam int NODE_COUNT_W = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_CODE   = 2'd2,
        CMD_COUNT  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [VID_W-1:0]  vertex_id;
        logic [VID_W-1:0]  neighbor_id;
        logic [CODE_W-1:0] code_word;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] triangle_count;
        logic               load_overflow;
    } res_t;

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_BUILD, ST_BUILD_ACC,
        ST_A_START, ST_A_CHK, ST_A_EDGE,
        ST_M_RDN, ST_M_RDC, ST_M_AND,
        ST_E_RDN, ST_E_RDB, ST_E_CHK, ST_E_EDGE, ST_E_NEXT,
        ST_W_RDN, ST_W_RDC, ST_W_CHK, ST_W_NEXT,
        ST_S_STEP, ST_S_CMP, ST_S_HIT,
        ST_A_NEXT, ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_APPEND, OP_CODE, OP_COUNT_INIT, OP_CLR_STEP,
        OP_BUILD_WR, OP_BUILD_ACC,
        OP_A_RD, OP_A_LOAD, OP_A_EDGE,
        OP_M_RDN, OP_M_RDC, OP_M_AND,
        OP_E_RDN, OP_E_RDB, OP_E_LOAD, OP_E_EDGE, OP_E_NEXT,
        OP_W_RDN, OP_W_RDC, OP_W_CHK, OP_W_NEXT,
        OP_S_RD, OP_S_CMP, OP_S_FRD, OP_S_HIT,
        OP_A_NEXT, OP_DONE
    } op_t;

    typedef struct packed {
        logic clr_last;
        logic k_last;
        logic a_done;
        logic a_empty;
        logic p_end;
        logic mask_zero;
        logic b_empty;
        logic no_overlap;
        logic q_end;
        logic share;
        logic len_zero;
        logic first_lt_hi;
    } st_t;

endpackage

// ===== rtl/tcc_ctrl.sv =====
// Sequencer of the triangle counter: issues one datapath operation per cycle.
module tcc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tcc_pkg::cmd_t cmd,
    input  tcc_pkg::st_t  st,
    output logic          busy,
    output tcc_pkg::op_t  op
);
    import tcc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            op         = OP_CLEAR;
                            state_next = ST_CLR;
                        end
                        CMD_APPEND: op = OP_APPEND;
                        CMD_CODE:   op = OP_CODE;
                        CMD_COUNT:
                        begin
                            op         = OP_COUNT_INIT;
                            state_next = ST_BUILD;
                        end
                        default: op = OP_NONE;
                    endcase
                end
            end
            ST_CLR:
            begin
                op = OP_CLR_STEP;
                if (st.clr_last)
                    state_next = ST_IDLE;
            end
            ST_BUILD:
            begin
                op         = OP_BUILD_WR;
                state_next = st.k_last ? ST_A_START : ST_BUILD_ACC;
            end
            ST_BUILD_ACC:
            begin
                op         = OP_BUILD_ACC;
                state_next = ST_BUILD;
            end
            ST_A_START:
            begin
                if (st.a_done)
                    state_next = ST_FINISH;
                else
                begin
                    op         = OP_A_RD;
                    state_next = ST_A_CHK;
                end
            end
            ST_A_CHK:
            begin
                op         = OP_A_LOAD;
                state_next = st.a_empty ? ST_A_NEXT : ST_A_EDGE;
            end
            ST_A_EDGE:
            begin
                op         = OP_A_EDGE;
                state_next = ST_M_RDN;
            end
            ST_M_RDN:
            begin
                // mask stayed nonzero over the whole list: drop the vertex
                if (st.p_end)
                    state_next = ST_A_NEXT;
                else
                begin
                    op         = OP_M_RDN;
                    state_next = ST_M_RDC;
                end
            end
            ST_M_RDC:
            begin
                op         = OP_M_RDC;
                state_next = ST_M_AND;
            end
            ST_M_AND:
            begin
                op         = OP_M_AND;
                state_next = st.mask_zero ? ST_E_RDN : ST_M_RDN;
            end
            ST_E_RDN:
            begin
                if (st.p_end)
                    state_next = ST_A_NEXT;
                else
                begin
                    op         = OP_E_RDN;
                    state_next = ST_E_RDB;
                end
            end
            ST_E_RDB:
            begin
                op         = OP_E_RDB;
                state_next = ST_E_CHK;
            end
            ST_E_CHK:
            begin
                op         = OP_E_LOAD;
                state_next = st.b_empty ? ST_E_NEXT : ST_E_EDGE;
            end
            ST_E_EDGE:
            begin
                op         = OP_E_EDGE;
                state_next = st.no_overlap ? ST_E_NEXT : ST_W_RDN;
            end
            ST_E_NEXT:
            begin
                op         = OP_E_NEXT;
                state_next = ST_E_RDN;
            end
            ST_W_RDN:
            begin
                if (st.q_end)
                    state_next = ST_E_NEXT;
                else
                begin
                    op         = OP_W_RDN;
                    state_next = ST_W_RDC;
                end
            end
            ST_W_RDC:
            begin
                op         = OP_W_RDC;
                state_next = ST_W_CHK;
            end
            ST_W_CHK:
            begin
                op         = OP_W_CHK;
                state_next = st.share ? ST_W_NEXT : ST_S_STEP;
            end
            ST_W_NEXT:
            begin
                op         = OP_W_NEXT;
                state_next = ST_W_RDN;
            end
            ST_S_STEP:
            begin
                if (!st.len_zero)
                begin
                    op         = OP_S_RD;
                    state_next = ST_S_CMP;
                end
                else if (st.first_lt_hi)
                begin
                    op         = OP_S_FRD;
                    state_next = ST_S_HIT;
                end
                else
                    state_next = ST_W_NEXT;
            end
            ST_S_CMP:
            begin
                op         = OP_S_CMP;
                state_next = ST_S_STEP;
            end
            ST_S_HIT:
            begin
                op         = OP_S_HIT;
                state_next = ST_W_NEXT;
            end
            ST_A_NEXT:
            begin
                op         = OP_A_NEXT;
                state_next = ST_A_START;
            end
            ST_FINISH:
            begin
                op         = OP_DONE;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/tcc_datapath.sv =====
// Stores, index registers and compare logic of the triangle counter.
module tcc_datapath #(
    parameter int MAX_NODES = tcc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = tcc_pkg::DEF_MAX_EDGES,
    parameter int CODE_BITS = tcc_pkg::DEF_CODE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tcc_pkg::op_t                       op,
    input  tcc_pkg::req_t                      req,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcc_pkg::NODE_COUNT_W-1:0]   cfg_data,
    output tcc_pkg::st_t                       st,
    output logic                               done,
    output tcc_pkg::res_t                      result
);
    import tcc_pkg::*;

    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int NAW = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    // stores
    logic [EW-1:0]        end_mem  [MAX_NODES];
    logic [EW-1:0]        rs_mem   [MAX_NODES+1];
    logic [VID_W-1:0]     nbr_mem  [MAX_EDGES];
    logic [CODE_BITS-1:0] code_mem [MAX_NODES];

    logic [EW-1:0]        end_q;
    logic [EW-1:0]        rs_q0, rs_q1;
    logic [VID_W-1:0]     nbr_q0, nbr_q1;
    logic [CODE_BITS-1:0] code_q;

    // control registers
    logic [EW-1:0]           fill_reg;
    logic                    ovf_reg;
    logic [NODE_COUNT_W-1:0] node_count_reg;
    logic [NAW-1:0]          clr_idx_reg;
    logic                    done_reg;

    // working registers
    logic [NW-1:0]        k_reg, a_reg;
    logic [EW-1:0]        run_reg;
    logic [EW-1:0]        ab_reg, ae_reg, p_reg;
    logic [EW-1:0]        bb_reg, be_reg;
    logic [EW-1:0]        q_reg, we_reg, lo_reg, hi_reg, first_reg, len_reg;
    logic [CODE_BITS-1:0] mask_reg, code_a_reg, code_b_reg, other_reg;
    logic [VID_W-1:0]     ea_first_reg, ea_last_reg, x_reg;
    logic                 x_in_reg, b_in_reg;
    logic [COUNT_W-1:0]   total_reg;
    res_t                 result_reg;

    logic                 v_ok, append_ok, nbr_in;
    logic [NW-1:0]        limit;
    logic [CODE_BITS-1:0] x_code, mask_new;
    logic [EW-1:0]        bb_in, be_in, half, mid;
    logic [EW-1:0]        nbr_ra0, nbr_ra1;
    logic [NW-1:0]        rs_ra0, rs_ra1;
    logic [NAW-1:0]       code_ra;
    logic                 end_we;
    logic [NAW-1:0]       end_wa;
    logic [EW-1:0]        end_wd;

    assign cfg_ready = 1'b1;
    assign v_ok      = (32'(req.vertex_id) < MAX_NODES);
    assign append_ok = v_ok && (32'(fill_reg) < MAX_EDGES);
    assign nbr_in    = (32'(nbr_q0) < MAX_NODES);
    assign limit     = (32'(node_count_reg) > MAX_NODES) ? NW'(MAX_NODES)
                                                         : NW'(node_count_reg);
    assign x_code    = x_in_reg ? code_q : '0;
    assign mask_new  = mask_reg & x_code;
    assign bb_in     = b_in_reg ? rs_q0 : '0;
    assign be_in     = b_in_reg ? rs_q1 : '0;
    assign half      = len_reg >> 1;
    assign mid       = first_reg + half;

    always_comb
    begin
        st.clr_last    = (clr_idx_reg == NAW'(MAX_NODES - 1));
        st.k_last      = (k_reg == NW'(MAX_NODES));
        st.a_done      = (a_reg == limit);
        st.a_empty     = (rs_q1 <= rs_q0);
        st.p_end       = (p_reg == ae_reg);
        st.mask_zero   = (mask_new == '0);
        st.b_empty     = (be_in <= bb_in);
        st.no_overlap  = (ea_last_reg < nbr_q0) || (ea_first_reg > nbr_q1);
        st.q_end       = (q_reg == we_reg);
        st.share       = ((x_code & other_reg) != '0);
        st.len_zero    = (len_reg == '0);
        st.first_lt_hi = (first_reg < hi_reg);
    end

    // read addresses
    always_comb
    begin
        nbr_ra0 = p_reg;
        nbr_ra1 = p_reg;
        rs_ra0  = a_reg;
        rs_ra1  = NW'(a_reg + NW'(1));
        code_ra = NAW'(a_reg);
        case (op)
            OP_A_LOAD:
            begin
                nbr_ra0 = rs_q0;
                nbr_ra1 = rs_q1 - EW'(1);
            end
            OP_M_RDC, OP_W_RDC, OP_E_RDB:
            begin
                code_ra = NAW'(nbr_q0);
                rs_ra0  = NW'(nbr_q0);
                rs_ra1  = NW'(nbr_q0) + NW'(1);
            end
            OP_E_LOAD:
            begin
                nbr_ra0 = bb_in;
                nbr_ra1 = be_in - EW'(1);
            end
            OP_W_RDN: nbr_ra0 = q_reg;
            OP_S_RD:  nbr_ra0 = mid;
            OP_S_FRD: nbr_ra0 = first_reg;
            default: ;
        endcase
    end

    always_comb
    begin
        end_we = 1'b0;
        end_wa = clr_idx_reg;
        end_wd = '0;
        if (op == OP_CLR_STEP)
            end_we = 1'b1;
        else if (op == OP_APPEND && append_ok)
        begin
            end_we = 1'b1;
            end_wa = NAW'(req.vertex_id);
            end_wd = fill_reg + EW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_we)
            end_mem[end_wa] <= end_wd;
        end_q <= end_mem[NAW'(k_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_BUILD_WR)
            rs_mem[k_reg] <= run_reg;
        rs_q0 <= rs_mem[rs_ra0];
        rs_q1 <= rs_mem[rs_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_APPEND && append_ok)
            nbr_mem[EAW'(fill_reg)] <= req.neighbor_id;
        nbr_q0 <= nbr_mem[EAW'(nbr_ra0)];
        nbr_q1 <= nbr_mem[EAW'(nbr_ra1)];
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_CODE && v_ok)
            code_mem[NAW'(req.vertex_id)] <= req.code_word[CODE_BITS-1:0];
        code_q <= code_mem[code_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
            node_count_reg <= '0;
            clr_idx_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= (op == OP_DONE);
            if (cfg_valid && cfg_ready)
                node_count_reg <= cfg_data;
            if (op == OP_CLEAR)
            begin
                fill_reg    <= '0;
                ovf_reg     <= 1'b0;
                clr_idx_reg <= '0;
            end
            if (op == OP_CLR_STEP)
                clr_idx_reg <= st.clr_last ? '0 : clr_idx_reg + NAW'(1);
            if (op == OP_APPEND && v_ok)
            begin
                if (append_ok)
                    fill_reg <= fill_reg + EW'(1);
                else
                    ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_COUNT_INIT:
            begin
                k_reg     <= '0;
                run_reg   <= '0;
                a_reg     <= '0;
                total_reg <= '0;
            end
            OP_BUILD_ACC:
            begin
                // list start of vertex k+1 is the latest append below it
                run_reg <= (end_q > run_reg) ? end_q : run_reg;
                k_reg   <= k_reg + NW'(1);
            end
            OP_A_LOAD:
            begin
                ab_reg     <= rs_q0;
                ae_reg     <= rs_q1;
                p_reg      <= rs_q0;
                code_a_reg <= code_q;
                mask_reg   <= '1;
            end
            OP_A_EDGE:
            begin
                ea_first_reg <= nbr_q0;
                ea_last_reg  <= nbr_q1;
            end
            OP_M_RDC, OP_W_RDC:
            begin
                x_reg    <= nbr_q0;
                x_in_reg <= nbr_in;
            end
            OP_M_AND:
            begin
                mask_reg <= mask_new;
                p_reg    <= (mask_new == '0) ? ab_reg : p_reg + EW'(1);
            end
            OP_E_RDB: b_in_reg <= nbr_in;
            OP_E_LOAD:
            begin
                bb_reg     <= bb_in;
                be_reg     <= be_in;
                code_b_reg <= b_in_reg ? code_q : '0;
            end
            OP_E_EDGE:
            begin
                // walk the shorter list, search the longer one
                if ((ae_reg - ab_reg) > (be_reg - bb_reg))
                begin
                    q_reg     <= bb_reg;
                    we_reg    <= be_reg;
                    lo_reg    <= ab_reg;
                    hi_reg    <= ae_reg;
                    other_reg <= code_a_reg;
                end
                else
                begin
                    q_reg     <= ab_reg;
                    we_reg    <= ae_reg;
                    lo_reg    <= bb_reg;
                    hi_reg    <= be_reg;
                    other_reg <= code_b_reg;
                end
            end
            OP_E_NEXT: p_reg <= p_reg + EW'(1);
            OP_W_CHK:
            begin
                first_reg <= lo_reg;
                len_reg   <= hi_reg - lo_reg;
            end
            OP_W_NEXT: q_reg <= q_reg + EW'(1);
            OP_S_CMP:
            begin
                if (nbr_q0 < x_reg)
                begin
                    first_reg <= mid + EW'(1);
                    len_reg   <= len_reg - half - EW'(1);
                end
                else
                    len_reg <= half;
            end
            OP_S_HIT:
            begin
                if (nbr_q0 == x_reg && total_reg != COUNT_MAX)
                    total_reg <= total_reg + COUNT_W'(1);
            end
            OP_A_NEXT: a_reg <= a_reg + NW'(1);
            OP_DONE:
            begin
                result_reg.triangle_count <= total_reg;
                result_reg.load_overflow  <= ovf_reg;
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/triangle_count_code_pruned.sv =====
// Top level of the code-pruned triangle counter.
// A word is taken when start is high and busy is low. Append-neighbor and
// write-code words keep busy low, so they can be issued every cycle. A clear
// word, and reset, start a sweep of the list-end store that holds busy high.
// A count word holds busy high while the sequencer rebuilds the list-start
// table and then walks the lists one store read at a time: per vertex it
// builds a prune mask from the codes of its neighbors, then checks each
// neighbor, walks the shorter of the two lists and binary-searches each
// walked element in the longer one.
// The result word appears on result with done high for one cycle, in the
// cycle in which busy falls, and cannot be held off.
// Configuration writes (node_count) are taken in any cycle.
module triangle_count_code_pruned #(
    parameter int MAX_NODES = tcc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = tcc_pkg::DEF_MAX_EDGES,
    parameter int CODE_BITS = tcc_pkg::DEF_CODE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  tcc_pkg::req_t                    req,
    output logic                             done,
    output tcc_pkg::res_t                    result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcc_pkg::NODE_COUNT_W-1:0] cfg_data
);
    import tcc_pkg::*;

    op_t op;
    st_t st;

    tcc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (req.cmd),
        .st    (st),
        .busy  (busy),
        .op    (op)
    );

    tcc_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .CODE_BITS (CODE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .st        (st),
        .done      (done),
        .result    (result)
    );

endmodule

// ===== rtl/tcc_checker.sv =====
// Port-level checks of the triangle counter and their bind.
`include "triangle_count_code_pruned_macros.svh"

module tcc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input tcc_pkg::req_t req,
    input logic          done
);
    import tcc_pkg::*;

    `TCC_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `TCC_ASSERT_NOW(a_done_after_busy, clk, rst_n, done, !busy && $past(busy))
    `TCC_ASSERT_NEXT(a_count_goes_busy, clk, rst_n, start && !busy && req.cmd == CMD_COUNT, busy)
    `TCC_ASSERT_NEXT(a_load_stays_idle, clk, rst_n, start && !busy && (req.cmd == CMD_APPEND || req.cmd == CMD_CODE), !busy && !done)

endmodule

bind triangle_count_code_pruned tcc_checker u_tcc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done)
);
